### hdl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and codes for the set-associative cache tag/LRU engine.
// ----------------------------------------------------------------------------
package sacl_pkg;

    typedef struct packed {
        logic        action;
        logic [31:0] address;
    } t_in;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        writeback_valid;
        logic [31:0] writeback_address;
    } t_out;

    localparam logic       ACT_STORE     = 1'b1;
    localparam logic [1:0] OUT_MAIN_HIT  = 2'd0;
    localparam logic [1:0] OUT_VICT_HIT  = 2'd1;
    localparam logic [1:0] OUT_MISS      = 2'd2;

    localparam int         REG_VICTIM_ENABLE = 0;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic read;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } t_sts;

endpackage

### hdl/set_assoc_cache_lru_victim_top.sv
// Result path: the input is registered on accept, the set row is read into a register, and the result
// is registered on commit, which waits while a receiver stall holds the result register. Accesses do not overlap.
// Reset: a clearing pass sweeps the 2**floor(log2(SETS)) rows of the set memory,
// one row a cycle; inputs stall during it. victim_enable resets to 1.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_victim_top
// Tag and LRU policy engine of a write-back cache with a victim buffer.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_victim_top #(
    parameter int SETS           = 64,
    parameter int WAYS           = 4,
    parameter int BLOCK_BYTES    = 32,
    parameter int VICTIM_ENTRIES = 4,
    parameter int ADDRESS_BITS   = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sacl_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sacl_pkg::t_out  o_out,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    sacl_pkg::t_cmd cmd;
    sacl_pkg::t_sts sts;
    logic           r_victim_enable;
    logic           reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (32'(paddr[2]) == sacl_pkg::REG_VICTIM_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_victim_enable <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_victim_enable <= pwdata[0];
        end
    end

    assign prdata = reg_sel ? {31'd0, r_victim_enable} : 32'd0;

    sacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sacl_dp #(
        .SETS           (SETS),
        .WAYS           (WAYS),
        .BLOCK_BYTES    (BLOCK_BYTES),
        .VICTIM_ENTRIES (VICTIM_ENTRIES),
        .ADDRESS_BITS   (ADDRESS_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in            (i_in),
        .i_victim_enable (r_victim_enable),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out           (o_out)
    );

endmodule

### hdl/sacl_ctrl.sv
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: clearing sweep after reset, then accept / read / update per item.
// ----------------------------------------------------------------------------
module sacl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sacl_pkg::t_sts  i_sts,
    output sacl_pkg::t_cmd  o_cmd
);

    sacl_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            sacl_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = sacl_pkg::S_IDLE;
            end
            sacl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sacl_pkg::S_READ;
                end
            end
            sacl_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = sacl_pkg::S_EXEC;
            end
            sacl_pkg::S_EXEC: begin
                // hold until the result register can take the new result
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = sacl_pkg::S_IDLE;
                end
            end
            default: n_state = sacl_pkg::S_CLEAR;
        endcase
    end

    assign o_in_stall = (r_state != sacl_pkg::S_IDLE);

endmodule

### hdl/sacl_dp.sv
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath: set memory, victim buffer registers, lookup and LRU update logic.
// ----------------------------------------------------------------------------
module sacl_dp #(
    parameter int SETS           = 64,
    parameter int WAYS           = 4,
    parameter int BLOCK_BYTES    = 32,
    parameter int VICTIM_ENTRIES = 4,
    parameter int ADDRESS_BITS   = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sacl_pkg::t_cmd  i_cmd,
    output sacl_pkg::t_sts  o_sts,
    input  sacl_pkg::t_in   i_in,
    input  logic            i_victim_enable,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output sacl_pkg::t_out  o_out
);

    function automatic int flog2(input int v);
        int r;
        int x;
        r = 0;
        x = v;
        while (x > 1) begin
            x = x / 2;
            r = r + 1;
        end
        return r;
    endfunction

    localparam int AW    = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
    localparam int BB    = flog2(BLOCK_BYTES);
    localparam int SB    = flog2(SETS);
    localparam int SROWS = 2 ** SB;
    localparam int SETW  = (SB > 0) ? SB : 1;
    localparam int BLKW  = AW - BB;
    localparam int TAGW  = BLKW - SB;
    localparam int AGW   = $clog2(WAYS + 1);
    localparam int VAGW  = $clog2(VICTIM_ENTRIES + 1);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int VW    = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
    localparam int ENTW  = TAGW + 2 + AGW;

    localparam logic [31:0]     AMASK = (AW >= 32) ? 32'hFFFF_FFFF
                                                   : 32'((64'd1 << AW) - 64'd1);
    localparam logic [BLKW-1:0] SMASK = BLKW'((64'd1 << SB) - 64'd1);
    localparam logic [AGW-1:0]  AGE_SAT  = AGW'(WAYS);
    localparam logic [VAGW-1:0] VAGE_SAT = VAGW'(VICTIM_ENTRIES);

    // set memory: one row holds every way of a set
    logic [WAYS-1:0][ENTW-1:0] mem [SROWS];
    logic [WAYS-1:0][ENTW-1:0] r_row;
    logic [WAYS-1:0][ENTW-1:0] n_row;

    logic [SETW-1:0] r_clr_addr;
    logic            r_action;
    logic [BLKW-1:0] r_blk;
    logic [SETW-1:0] set_idx;
    logic [TAGW-1:0] tag;

    // victim buffer
    logic [BLKW-1:0] r_vtag   [VICTIM_ENTRIES];
    logic            r_vval   [VICTIM_ENTRIES];
    logic            r_vdirty [VICTIM_ENTRIES];
    logic [VAGW-1:0] r_vage   [VICTIM_ENTRIES];
    logic [BLKW-1:0] n_vtag   [VICTIM_ENTRIES];
    logic            n_vval   [VICTIM_ENTRIES];
    logic            n_vdirty [VICTIM_ENTRIES];
    logic [VAGW-1:0] n_vage   [VICTIM_ENTRIES];

    logic [TAGW-1:0] mt [WAYS];
    logic            mv [WAYS];
    logic            md [WAYS];
    logic [AGW-1:0]  ma [WAYS];
    logic [TAGW-1:0] n_mt [WAYS];
    logic            n_mv [WAYS];
    logic            n_md [WAYS];
    logic [AGW-1:0]  n_ma [WAYS];

    logic            r_out_valid;
    sacl_pkg::t_out  r_out, n_out;

    assign set_idx = SETW'(r_blk & SMASK);
    assign tag     = TAGW'(r_blk >> SB);

    // ---------------- lookup and update ----------------
    logic            hit, full, vhit, vfree, m_place, v_upd, v_place;
    logic [WW-1:0]   hway, fway, lru, m_idx;
    logic [VW-1:0]   vidx, vfidx, vlru, v_idx;
    logic [AGW-1:0]  mx;
    logic [VAGW-1:0] vmx;
    logic [BLKW-1:0] lru_blk;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            ma[w] = r_row[w][AGW-1:0];
            md[w] = r_row[w][AGW];
            mv[w] = r_row[w][AGW+1];
            mt[w] = r_row[w][ENTW-1:AGW+2];
        end

        hit = 1'b0;
        hway = '0;
        full = 1'b1;
        fway = '0;
        lru = '0;
        mx = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && mv[w] && (mt[w] == tag)) begin
                hit  = 1'b1;
                hway = WW'(w);
            end
            if (full && !mv[w]) begin
                full = 1'b0;
                fway = WW'(w);
            end
            // ties go to the highest-numbered way
            if (mv[w] && (ma[w] >= mx)) begin
                lru = WW'(w);
                mx  = ma[w];
            end
        end

        vhit = 1'b0;
        vidx = '0;
        vfree = 1'b0;
        vfidx = '0;
        vlru = '0;
        vmx = '0;
        for (int v = 0; v < VICTIM_ENTRIES; v++) begin
            if (!vhit && r_vval[v] && (r_vtag[v] == r_blk)) begin
                vhit = 1'b1;
                vidx = VW'(v);
            end
            if (!vfree && !r_vval[v]) begin
                vfree = 1'b1;
                vfidx = VW'(v);
            end
            if (r_vval[v] && (r_vage[v] >= vmx)) begin
                vlru = VW'(v);
                vmx  = r_vage[v];
            end
        end

        lru_blk = (BLKW'(mt[lru]) << SB) | BLKW'(set_idx);

        for (int w = 0; w < WAYS; w++) begin
            n_mt[w] = mt[w];
            n_mv[w] = mv[w];
            n_md[w] = md[w];
        end
        for (int v = 0; v < VICTIM_ENTRIES; v++) begin
            n_vtag[v]   = r_vtag[v];
            n_vval[v]   = r_vval[v];
            n_vdirty[v] = r_vdirty[v];
        end

        n_out   = '0;
        n_out.outcome = sacl_pkg::OUT_MISS;
        m_place = 1'b1;
        m_idx   = lru;
        v_upd   = 1'b0;
        v_place = 1'b1;
        v_idx   = vidx;

        if (hit) begin
            if (r_action == sacl_pkg::ACT_STORE) n_md[hway] = 1'b1;
            m_place = 1'b0;
            m_idx   = hway;
            n_out.outcome = sacl_pkg::OUT_MAIN_HIT;
        end else if (i_victim_enable && full) begin
            if (vhit) begin
                // swap the buffer entry with the set's LRU line
                n_mt[lru]      = TAGW'(r_vtag[vidx] >> SB);
                n_md[lru]      = r_vdirty[vidx] | (r_action == sacl_pkg::ACT_STORE);
                n_vtag[vidx]   = lru_blk;
                n_vdirty[vidx] = md[lru];
                v_upd   = 1'b1;
                v_place = 1'b0;
                v_idx   = vidx;
                n_out.outcome = sacl_pkg::OUT_VICT_HIT;
            end else begin
                v_idx = vfree ? vfidx : vlru;
                if (!vfree && r_vdirty[vlru]) begin
                    n_out.writeback_valid   = 1'b1;
                    n_out.writeback_address = 32'(r_vtag[vlru]) << BB;
                end
                n_vtag[v_idx]   = lru_blk;
                n_vdirty[v_idx] = md[lru];
                n_vval[v_idx]   = 1'b1;
                v_upd = 1'b1;
                n_mt[lru] = tag;
                n_md[lru] = (r_action == sacl_pkg::ACT_STORE);
                n_mv[lru] = 1'b1;
            end
        end else begin
            m_idx = full ? lru : fway;
            if (full && md[lru]) begin
                n_out.writeback_valid   = 1'b1;
                n_out.writeback_address = 32'(lru_blk) << BB;
            end
            n_mt[m_idx] = tag;
            n_md[m_idx] = (r_action == sacl_pkg::ACT_STORE);
            n_mv[m_idx] = 1'b1;
        end

        // main ages: placement ages every other valid line below saturation, a touch only younger ones
        for (int w = 0; w < WAYS; w++) begin
            n_ma[w] = ma[w];
            if ((WW'(w) != m_idx) && mv[w] && (ma[w] != AGE_SAT)
                    && (m_place || (ma[w] < ma[m_idx]))) begin
                n_ma[w] = AGW'(ma[w] + 1'b1);
            end
        end
        n_ma[m_idx] = '0;

        for (int v = 0; v < VICTIM_ENTRIES; v++) begin
            n_vage[v] = r_vage[v];
            if (v_upd && (VW'(v) != v_idx) && r_vval[v] && (r_vage[v] != VAGE_SAT)
                    && (v_place || (r_vage[v] < r_vage[v_idx]))) begin
                n_vage[v] = VAGW'(r_vage[v] + 1'b1);
            end
        end
        if (v_upd) n_vage[v_idx] = '0;

        for (int w = 0; w < WAYS; w++) begin
            n_row[w] = {n_mt[w], n_mv[w], n_md[w], n_ma[w]};
        end
    end

    // ---------------- storage ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.commit) begin
            mem[set_idx] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) r_row <= mem[set_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= SETW'(r_clr_addr + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_in.action;
            r_blk    <= BLKW'((i_in.address & AMASK) >> BB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VICTIM_ENTRIES; v++) begin
                r_vval[v]   <= 1'b0;
                r_vdirty[v] <= 1'b0;
                r_vage[v]   <= '0;
            end
        end else if (i_cmd.commit) begin
            for (int v = 0; v < VICTIM_ENTRIES; v++) begin
                r_vval[v]   <= n_vval[v];
                r_vdirty[v] <= n_vdirty[v];
                r_vage[v]   <= n_vage[v];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int v = 0; v < VICTIM_ENTRIES; v++) begin
                r_vtag[v] <= n_vtag[v];
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;
    assign o_sts.clr_last = (r_clr_addr == SETW'(SROWS - 1));
    assign o_sts.out_busy = r_out_valid && i_out_stall;

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed load/store transfers into the cache tag/LRU
// engine, predicts outcome and dirty writebacks, and checks every result.
// ----------------------------------------------------------------------------
class cache_scoreboard;
    localparam int NSETS = 64;
    localparam int NWAYS = 4;
    localparam int NVICT = 4;
    localparam int OFFB  = 5;
    localparam int SETB  = 6;

    bit [20:0] mtag [NSETS][NWAYS];
    bit        mval [NSETS][NWAYS];
    bit        mdirty [NSETS][NWAYS];
    int        mage [NSETS][NWAYS];
    bit [26:0] vtag [NVICT];
    bit        vval [NVICT];
    bit        vdirty [NVICT];
    int        vage [NVICT];
    bit        victim_on;
    sacl_pkg::t_out pending [$];
    int        errors;

    function new();
        victim_on = 1'b1;
        errors = 0;
    endfunction

    function int oldest(int ag[], bit va[], int n);
        int best;
        int mx;
        best = 0;
        mx = 0;
        for (int i = 0; i < n; i++)
            if (va[i] && ag[i] >= mx) begin
                best = i;
                mx = ag[i];
            end
        return best;
    endfunction

    // mark idx most recent; fresh placement ages all other valid ones below saturation, re-touch only younger
    function void make_mru(ref int ag[], input bit va[], input int n, input int idx,
                           input bit fresh);
        int was;
        was = ag[idx];
        ag[idx] = 0;
        for (int i = 0; i < n; i++)
            if (i != idx && va[i] && ag[i] != n && (fresh || ag[i] < was))
                ag[i]++;
    endfunction

    function void note_access(sacl_pkg::t_in it);
        sacl_pkg::t_out r;
        bit [26:0] blk;
        bit [5:0]  s;
        bit [20:0] tg;
        bit [20:0] ot;
        bit        od;
        bit        hit;
        bit        full;
        bit        vhit;
        bit        vfree;
        int        way;
        int        lru;
        int        v;
        int        ag[];
        bit        va[];
        blk = it.address[31:OFFB];
        s = blk[5:0];
        tg = blk[26:SETB];
        r = '0;
        r.outcome = sacl_pkg::OUT_MISS;
        hit = 0;
        full = 1;
        way = 0;
        ag = new[NWAYS];
        va = new[NWAYS];
        for (int i = 0; i < NWAYS; i++) begin
            ag[i] = mage[s][i];
            va[i] = mval[s][i];
        end
        for (int i = 0; i < NWAYS; i++)
            if (!hit && mval[s][i] && mtag[s][i] == tg) begin
                hit = 1;
                way = i;
            end
        if (hit) begin
            if (it.action == sacl_pkg::ACT_STORE) mdirty[s][way] = 1;
            make_mru(ag, va, NWAYS, way, 0);
            r.outcome = sacl_pkg::OUT_MAIN_HIT;
        end else begin
            for (int i = NWAYS - 1; i >= 0; i--)
                if (!mval[s][i]) begin
                    full = 0;
                    way = i;
                end
            if (victim_on && full) begin
                int vag[];
                bit vva[];
                vag = new[NVICT];
                vva = new[NVICT];
                for (int i = 0; i < NVICT; i++) begin
                    vag[i] = vage[i];
                    vva[i] = vval[i];
                end
                lru = oldest(ag, va, NWAYS);
                vhit = 0;
                v = 0;
                for (int i = NVICT - 1; i >= 0; i--)
                    if (vval[i] && vtag[i] == blk) begin
                        vhit = 1;
                        v = i;
                    end
                if (vhit) begin
                    ot = mtag[s][lru];
                    od = mdirty[s][lru];
                    mtag[s][lru] = vtag[v][26:SETB];
                    mdirty[s][lru] = vdirty[v] | (it.action == sacl_pkg::ACT_STORE);
                    vtag[v] = {ot, s};
                    vdirty[v] = od;
                    make_mru(vag, vva, NVICT, v, 0);
                    make_mru(ag, va, NWAYS, lru, 1);
                    r.outcome = sacl_pkg::OUT_VICT_HIT;
                end else begin
                    vfree = 0;
                    for (int i = NVICT - 1; i >= 0; i--)
                        if (!vval[i]) begin
                            vfree = 1;
                            v = i;
                        end
                    if (!vfree) begin
                        v = oldest(vag, vva, NVICT);
                        if (vdirty[v]) begin
                            r.writeback_valid = 1;
                            r.writeback_address = {vtag[v], 5'b0};
                        end
                    end
                    vtag[v] = {mtag[s][lru], s};
                    vdirty[v] = mdirty[s][lru];
                    vval[v] = 1;
                    vva[v] = 1;
                    make_mru(vag, vva, NVICT, v, 1);
                    mtag[s][lru] = tg;
                    mdirty[s][lru] = (it.action == sacl_pkg::ACT_STORE);
                    make_mru(ag, va, NWAYS, lru, 1);
                end
                for (int i = 0; i < NVICT; i++) vage[i] = vag[i];
            end else begin
                if (full) begin
                    way = oldest(ag, va, NWAYS);
                    if (mdirty[s][way]) begin
                        r.writeback_valid = 1;
                        r.writeback_address = {mtag[s][way], s, 5'b0};
                    end
                end
                mtag[s][way] = tg;
                mdirty[s][way] = (it.action == sacl_pkg::ACT_STORE);
                mval[s][way] = 1;
                va[way] = 1;
                make_mru(ag, va, NWAYS, way, 1);
            end
        end
        for (int i = 0; i < NWAYS; i++) mage[s][i] = ag[i];
        pending.push_back(r);
    endfunction

    function void check_result(sacl_pkg::t_out got);
        sacl_pkg::t_out exp;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
        end
        exp = pending.pop_front();
        if (got.outcome !== exp.outcome || got.writeback_valid !== exp.writeback_valid ||
            got.writeback_address !== exp.writeback_address) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp outcome %0d wb %0b addr %h, got %0d %0b %h",
                         exp.outcome, exp.writeback_valid, exp.writeback_address,
                         got.outcome, got.writeback_valid, got.writeback_address);
        end
    endfunction
endclass

module testbench;
    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    sacl_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_stall;
    sacl_pkg::t_out o_out;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    cache_scoreboard sb;
    int  cycles;
    int  hold_off;  // long receiver stall request, cycles

    set_assoc_cache_lru_victim_top dut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // valid stays high into the next transfer when there is no gap
    task automatic send_access(bit act, bit [31:0] addr);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_in.action <= act;
        i_in.address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_access(i_in);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_victim_enable(bit en);
        drain();
        psel <= 1;
        pwrite <= 1;
        paddr <= 3'(4 * sacl_pkg::REG_VICTIM_ENABLE);
        pwdata <= {31'b0, en};
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        sb.victim_on = en;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // small pool of tags per set so hits, victim hits and evictions all occur
    function automatic bit [31:0] pool_addr(int nsets, int ntags);
        bit [31:0] a;
        a = $urandom();
        a[10:5] = 6'($urandom_range(0, nsets - 1));
        a[31:11] = 21'($urandom_range(0, ntags - 1)) ^ (a[31] ? 21'h1FFFFF : 21'h0);
        return a;
    endfunction

    task automatic random_phase(int n, int nsets, int ntags);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_access(1'($urandom_range(0, 1)), $urandom());
            else
                send_access(1'($urandom_range(0, 1)), pool_addr(nsets, ntags));
        end
    endtask

    // receiver
    initial begin
        int w;
        i_out_stall = 0;
        hold_off = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_out_stall <= 1;
                repeat (hold_off) @(negedge i_clk);
                hold_off = 0;
            end
            w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            if (w > 0) begin
                i_out_stall <= 1;
                repeat (w - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_out_stall <= 0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);

    initial begin
        sb = new();
        i_rst_n = 0;
        i_in_valid = 0;
        i_in = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        // directed: field extremes, fill one set, victim hits, dirty evictions
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b1, 32'hFFFF_FFFF);
        send_access(1'b0, 32'h0000_0001);
        for (int t = 1; t <= 6; t++) send_access(t[0], {21'(t), 6'd3, 5'd7});
        send_access(1'b1, {21'd1, 6'd3, 5'd0});
        send_access(1'b0, {21'd2, 6'd3, 5'd0});
        send_access(1'b1, {21'd1, 6'd3, 5'd0});
        for (int t = 7; t <= 12; t++) send_access(1'b1, {21'(t), 6'd3, 5'd0});
        write_victim_enable(1'b0);
        for (int t = 0; t <= 6; t++) send_access(t[0], {21'(t + 20), 6'd63, 5'd31});
        send_access(1'b0, {21'd9, 6'd3, 5'd0});
        // long receiver hold-off while the sender keeps going
        hold_off = 60;
        random_phase(20, 2, 6);
        drain();
        random_phase(120, 4, 8);
        write_victim_enable(1'b1);
        random_phase(220, 4, 9);
        write_victim_enable(1'b0);
        random_phase(80, 8, 7);
        write_victim_enable(1'b1);
        hold_off = 80;
        random_phase(180, 64, 10);
        drain();
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

### set_assoc_cache_lru_victim_top.f
hdl/sacl_pkg.sv
hdl/sacl_ctrl.sv
hdl/sacl_dp.sv
hdl/set_assoc_cache_lru_victim_top.sv
sim/testbench.sv
